/* rtl/pinhole_camera_ray_generator_top_assert.svh */
// Assertion macros for the pinhole camera ray generator checker.
// Used by pcrg_port_checker.sv; no other dependencies.
`ifndef PINHOLE_CAMERA_RAY_GENERATOR_TOP_ASSERT_SVH
`define PINHOLE_CAMERA_RAY_GENERATOR_TOP_ASSERT_SVH

// Antecedent implies consequent in the same cycle, off during reset.
`define PCRG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition must never hold, off during reset.
`define PCRG_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* rtl/pcrg_pkg.sv */
// Shared types and constants of the pinhole camera ray generator.
// No dependencies; imported by the normalizer, the top level, the checker and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package pcrg_pkg;

    localparam int CFG_W       = 32;
    localparam int NUM_CFG     = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int FIELD_W     = 32;
    localparam int MAG_W       = 64;
    localparam int UNIT_W      = 31;
    localparam int LEN_W       = 32;
    localparam int NORM_LEVELS = 6;
    localparam int RQ_W        = 61;
    localparam int NORM_LAT    = 74;
    localparam int PIPE_LAT    = 2 * NORM_LAT + RQ_W + 6;

    localparam logic [MAG_W-1:0] RECIP_SAT = 64'h1FFF_FFFF_FFFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CORNER_X = 3'd0,
        CFG_CORNER_Y = 3'd1,
        CFG_CORNER_Z = 3'd2,
        CFG_X_STEP_X = 3'd3,
        CFG_X_STEP_Z = 3'd4,
        CFG_Y_STEP_X = 3'd5,
        CFG_Y_STEP_Y = 3'd6,
        CFG_Y_STEP_Z = 3'd7
    } cfg_idx_e;

    typedef logic [2:0][MAG_W-1:0]   mag_vec_t;
    typedef logic [2:0][UNIT_W-1:0]  unit_vec_t;
    typedef logic [2:0][FIELD_W-1:0] field_vec_t;

    function automatic logic signed [CFG_W-1:0] cfg_reset(input cfg_idx_e idx);
        logic signed [CFG_W-1:0] val;
        case (idx)
            CFG_CORNER_Z: val = 32'shFF00_0000;
            default:      val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

/* rtl/pcrg_norm3.sv */
// Pipelined normalizer of a 3-vector of 64-bit magnitudes to unsigned unit Q1.30.
// Depends on pcrg_pkg; instanced twice by the top level.
`timescale 1ns / 1ps
`default_nettype none

module pcrg_norm3 #(
    parameter int SIDE_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  pcrg_pkg::mag_vec_t  in_mag,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output pcrg_pkg::unit_vec_t out_mag,
    output logic [SIDE_W-1:0]   out_side
);
    import pcrg_pkg::*;

    localparam int REM_W = LEN_W + 2;
    localparam int NUM_W = UNIT_W + 31;

    // normalize shift levels; index 0 is the max-capture stage
    logic              sh_valid_reg [0:NORM_LEVELS];
    logic              sh_valid_next[0:NORM_LEVELS];
    mag_vec_t          sh_mag_reg   [0:NORM_LEVELS];
    mag_vec_t          sh_mag_next  [0:NORM_LEVELS];
    logic [MAG_W-1:0]  sh_max_reg   [0:NORM_LEVELS];
    logic [MAG_W-1:0]  sh_max_next  [0:NORM_LEVELS];
    logic [SIDE_W-1:0] sh_side_reg  [0:NORM_LEVELS];
    logic [SIDE_W-1:0] sh_side_next [0:NORM_LEVELS];

    // squares
    logic                      sq_valid_reg, sq_valid_next;
    unit_vec_t                 sq_a_reg, sq_a_next;
    logic [2:0][2*UNIT_W-1:0]  sq_reg, sq_next;
    logic                      sq_zero_reg, sq_zero_next;
    logic [SIDE_W-1:0]         sq_side_reg, sq_side_next;

    // square root; index 0 holds the sum of squares
    logic              rt_valid_reg [0:LEN_W];
    logic              rt_valid_next[0:LEN_W];
    logic [MAG_W-1:0]  rt_rad_reg   [0:LEN_W];
    logic [MAG_W-1:0]  rt_rad_next  [0:LEN_W];
    logic [REM_W-1:0]  rt_rem_reg   [0:LEN_W];
    logic [REM_W-1:0]  rt_rem_next  [0:LEN_W];
    logic [LEN_W-1:0]  rt_root_reg  [0:LEN_W];
    logic [LEN_W-1:0]  rt_root_next [0:LEN_W];
    unit_vec_t         rt_a_reg     [0:LEN_W];
    unit_vec_t         rt_a_next    [0:LEN_W];
    logic              rt_zero_reg  [0:LEN_W];
    logic              rt_zero_next [0:LEN_W];
    logic [SIDE_W-1:0] rt_side_reg  [0:LEN_W];
    logic [SIDE_W-1:0] rt_side_next [0:LEN_W];

    // division lanes; index 0 holds the rounded numerators
    logic                     dv_valid_reg [0:UNIT_W];
    logic                     dv_valid_next[0:UNIT_W];
    logic [2:0][LEN_W-1:0]    dv_rem_reg   [0:UNIT_W];
    logic [2:0][LEN_W-1:0]    dv_rem_next  [0:UNIT_W];
    logic [2:0][UNIT_W-1:0]   dv_num_reg   [0:UNIT_W];
    logic [2:0][UNIT_W-1:0]   dv_num_next  [0:UNIT_W];
    logic [2:0][UNIT_W-1:0]   dv_q_reg     [0:UNIT_W];
    logic [2:0][UNIT_W-1:0]   dv_q_next    [0:UNIT_W];
    logic [LEN_W-1:0]         dv_len_reg   [0:UNIT_W];
    logic [LEN_W-1:0]         dv_len_next  [0:UNIT_W];
    logic                     dv_zero_reg  [0:UNIT_W];
    logic                     dv_zero_next [0:UNIT_W];
    logic [SIDE_W-1:0]        dv_side_reg  [0:UNIT_W];
    logic [SIDE_W-1:0]        dv_side_next [0:UNIT_W];

    logic              out_valid_reg, out_valid_next;
    unit_vec_t         out_mag_reg, out_mag_next;
    logic [SIDE_W-1:0] out_side_reg, out_side_next;

    always_comb
    begin
        logic [MAG_W-1:0]    m01;
        logic [REM_W+1:0]    rin;
        logic [REM_W+1:0]    trial;
        logic [NUM_W-1:0]    num;
        logic [LEN_W:0]      drin;

        // largest magnitude
        m01 = (in_mag[1] > in_mag[0]) ? in_mag[1] : in_mag[0];
        sh_valid_next[0] = in_valid;
        sh_mag_next[0]   = in_mag;
        sh_max_next[0]   = (in_mag[2] > m01) ? in_mag[2] : m01;
        sh_side_next[0]  = in_side;

        // shift left until the largest has its top bit set
        for (int l = 1; l <= NORM_LEVELS; l++)
        begin
            sh_valid_next[l] = sh_valid_reg[l-1];
            sh_side_next[l]  = sh_side_reg[l-1];
            if ((sh_max_reg[l-1] >> (MAG_W - (MAG_W >> l))) == '0)
            begin
                sh_max_next[l] = sh_max_reg[l-1] << (MAG_W >> l);
                for (int i = 0; i < 3; i++)
                    sh_mag_next[l][i] = sh_mag_reg[l-1][i] << (MAG_W >> l);
            end
            else
            begin
                sh_max_next[l] = sh_max_reg[l-1];
                sh_mag_next[l] = sh_mag_reg[l-1];
            end
        end

        // top 31 bits are the scaled components
        sq_valid_next = sh_valid_reg[NORM_LEVELS];
        sq_zero_next  = !sh_max_reg[NORM_LEVELS][MAG_W-1];
        sq_side_next  = sh_side_reg[NORM_LEVELS];
        for (int i = 0; i < 3; i++)
        begin
            sq_a_next[i] = sh_mag_reg[NORM_LEVELS][i][MAG_W-1 -: UNIT_W];
            sq_next[i]   = sq_a_next[i] * sq_a_next[i];
        end

        rt_valid_next[0] = sq_valid_reg;
        rt_rad_next[0]   = MAG_W'(sq_reg[0]) + MAG_W'(sq_reg[1]) + MAG_W'(sq_reg[2]);
        rt_rem_next[0]   = '0;
        rt_root_next[0]  = '0;
        rt_a_next[0]     = sq_a_reg;
        rt_zero_next[0]  = sq_zero_reg;
        rt_side_next[0]  = sq_side_reg;

        // one root bit per stage
        for (int k = 1; k <= LEN_W; k++)
        begin
            rin   = {rt_rem_reg[k-1], rt_rad_reg[k-1][MAG_W-1 -: 2]};
            trial = {2'b00, rt_root_reg[k-1], 2'b01};
            rt_valid_next[k] = rt_valid_reg[k-1];
            rt_rad_next[k]   = rt_rad_reg[k-1] << 2;
            rt_a_next[k]     = rt_a_reg[k-1];
            rt_zero_next[k]  = rt_zero_reg[k-1];
            rt_side_next[k]  = rt_side_reg[k-1];
            if (rin >= trial)
            begin
                rt_rem_next[k]  = REM_W'(rin - trial);
                rt_root_next[k] = {rt_root_reg[k-1][LEN_W-2:0], 1'b1};
            end
            else
            begin
                rt_rem_next[k]  = REM_W'(rin);
                rt_root_next[k] = {rt_root_reg[k-1][LEN_W-2:0], 1'b0};
            end
        end

        // rounded numerators: a * 2^30 + len / 2
        dv_valid_next[0] = rt_valid_reg[LEN_W];
        dv_len_next[0]   = rt_root_reg[LEN_W];
        dv_zero_next[0]  = rt_zero_reg[LEN_W];
        dv_side_next[0]  = rt_side_reg[LEN_W];
        for (int i = 0; i < 3; i++)
        begin
            num = {rt_a_reg[LEN_W][i], 31'd0} >> 1;
            num = num + NUM_W'(rt_root_reg[LEN_W] >> 1);
            dv_rem_next[0][i] = {1'b0, num[NUM_W-1 -: UNIT_W]};
            dv_num_next[0][i] = num[UNIT_W-1:0];
            dv_q_next[0][i]   = '0;
        end

        // one quotient bit per stage
        for (int j = 1; j <= UNIT_W; j++)
        begin
            dv_valid_next[j] = dv_valid_reg[j-1];
            dv_len_next[j]   = dv_len_reg[j-1];
            dv_zero_next[j]  = dv_zero_reg[j-1];
            dv_side_next[j]  = dv_side_reg[j-1];
            for (int i = 0; i < 3; i++)
            begin
                drin = {dv_rem_reg[j-1][i], dv_num_reg[j-1][i][UNIT_W-1]};
                dv_num_next[j][i] = dv_num_reg[j-1][i] << 1;
                if (drin >= {1'b0, dv_len_reg[j-1]})
                begin
                    dv_rem_next[j][i] = LEN_W'(drin - {1'b0, dv_len_reg[j-1]});
                    dv_q_next[j][i]   = {dv_q_reg[j-1][i][UNIT_W-2:0], 1'b1};
                end
                else
                begin
                    dv_rem_next[j][i] = LEN_W'(drin);
                    dv_q_next[j][i]   = {dv_q_reg[j-1][i][UNIT_W-2:0], 1'b0};
                end
            end
        end

        out_valid_next = dv_valid_reg[UNIT_W];
        out_side_next  = dv_side_reg[UNIT_W];
        out_mag_next   = dv_zero_reg[UNIT_W] ? '0 : dv_q_reg[UNIT_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l <= NORM_LEVELS; l++)
                sh_valid_reg[l] <= 1'b0;
            sq_valid_reg <= 1'b0;
            for (int k = 0; k <= LEN_W; k++)
                rt_valid_reg[k] <= 1'b0;
            for (int j = 0; j <= UNIT_W; j++)
                dv_valid_reg[j] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sh_valid_reg  <= sh_valid_next;
            sq_valid_reg  <= sq_valid_next;
            rt_valid_reg  <= rt_valid_next;
            dv_valid_reg  <= dv_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_mag_reg   <= sh_mag_next;
        sh_max_reg   <= sh_max_next;
        sh_side_reg  <= sh_side_next;
        sq_a_reg     <= sq_a_next;
        sq_reg       <= sq_next;
        sq_zero_reg  <= sq_zero_next;
        sq_side_reg  <= sq_side_next;
        rt_rad_reg   <= rt_rad_next;
        rt_rem_reg   <= rt_rem_next;
        rt_root_reg  <= rt_root_next;
        rt_a_reg     <= rt_a_next;
        rt_zero_reg  <= rt_zero_next;
        rt_side_reg  <= rt_side_next;
        dv_rem_reg   <= dv_rem_next;
        dv_num_reg   <= dv_num_next;
        dv_q_reg     <= dv_q_next;
        dv_len_reg   <= dv_len_next;
        dv_zero_reg  <= dv_zero_next;
        dv_side_reg  <= dv_side_next;
        out_mag_reg  <= out_mag_next;
        out_side_reg <= out_side_next;
    end

    assign out_valid = out_valid_reg;
    assign out_mag   = out_mag_reg;
    assign out_side  = out_side_reg;

endmodule

`default_nettype wire

/* rtl/pinhole_camera_ray_generator_top.sv */
// Pinhole camera primary ray generator: pixel in, unit and reciprocal direction out.
// Depends on pcrg_pkg and pcrg_norm3.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+-------------------------
//   config   | cfg_wr_en, cfg_index, cfg_data          | write when cfg_wr_en high
//   request  | start, busy, pixel_x, pixel_y           | taken when start && !busy
//   result   | done, dir_*, inv_*, zero_component      | one-cycle strobe on done
//
// One request per cycle; busy stays low. Each result passes from its request
// through three input stages, two 74-stage normalizers (each with a
// 33-stage square root and a 32-stage unit division), the 62-stage reciprocal
// division, the saturation stage and the output register.
// Reset clears all valid bits and loads the register defaults.
// The receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps
`default_nettype none

module pinhole_camera_ray_generator_top #(
    parameter int COORD_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [pcrg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pcrg_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic [COORD_BITS-1:0]             pixel_x,
    input  logic [COORD_BITS-1:0]             pixel_y,
    output logic                              done,
    output logic signed [pcrg_pkg::FIELD_W-1:0] dir_x,
    output logic signed [pcrg_pkg::FIELD_W-1:0] dir_y,
    output logic signed [pcrg_pkg::FIELD_W-1:0] dir_z,
    output logic signed [pcrg_pkg::FIELD_W-1:0] inv_x,
    output logic signed [pcrg_pkg::FIELD_W-1:0] inv_y,
    output logic signed [pcrg_pkg::FIELD_W-1:0] inv_z,
    output logic                              zero_component
);
    import pcrg_pkg::*;

    localparam int PW   = COORD_BITS + CFG_W + 1;
    localparam int VW   = PW + 2;
    localparam int RD_W = UNIT_W;

    typedef struct packed {
        field_vec_t dir;
        logic [2:0] rneg;
        logic [2:0] zero;
    } rc_side_t;

    typedef struct packed {
        field_vec_t dir;
        logic [2:0] rneg;
        logic       flag;
    } out_side_t;

    logic signed [CFG_W-1:0] cfg_reg [0:NUM_CFG-1];

    logic                 s1_valid_reg;
    logic signed [PW-1:0] s1_xsx_reg, s1_ysx_reg, s1_ysy_reg, s1_xsz_reg, s1_ysz_reg;
    logic signed [PW-1:0] s1_xsx_next, s1_ysx_next, s1_ysy_next, s1_xsz_next, s1_ysz_next;

    logic                 s2_valid_reg;
    logic signed [VW-1:0] s2_v_reg [0:2];
    logic signed [VW-1:0] s2_v_next[0:2];

    logic                 s3_valid_reg;
    mag_vec_t             s3_mag_reg, s3_mag_next;
    logic [2:0]           s3_neg_reg, s3_neg_next;

    logic                 n1_valid;
    unit_vec_t            n1_mag;
    logic [2:0]           n1_neg;

    // reciprocal division lanes; index 0 holds the numerators
    logic                   rc_valid_reg [0:RQ_W];
    logic                   rc_valid_next[0:RQ_W];
    logic [2:0][RD_W-1:0]   rc_rem_reg   [0:RQ_W];
    logic [2:0][RD_W-1:0]   rc_rem_next  [0:RQ_W];
    logic [2:0][RQ_W-1:0]   rc_num_reg   [0:RQ_W];
    logic [2:0][RQ_W-1:0]   rc_num_next  [0:RQ_W];
    logic [2:0][RQ_W-1:0]   rc_q_reg     [0:RQ_W];
    logic [2:0][RQ_W-1:0]   rc_q_next    [0:RQ_W];
    unit_vec_t              rc_d_reg     [0:RQ_W];
    unit_vec_t              rc_d_next    [0:RQ_W];
    rc_side_t               rc_side_reg  [0:RQ_W];
    rc_side_t               rc_side_next [0:RQ_W];

    logic                   rm_valid_reg;
    mag_vec_t               rm_mag_reg, rm_mag_next;
    out_side_t              rm_side_reg, rm_side_next;

    logic                   n2_valid;
    unit_vec_t              n2_mag;
    logic [$bits(out_side_t)-1:0] n2_side_bits;
    out_side_t              n2_side;

    logic                   done_reg;
    field_vec_t             dir_reg, dir_next;
    field_vec_t             inv_reg, inv_next;
    logic                   zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CFG; i++)
                cfg_reg[i] <= cfg_reset(cfg_idx_e'(CFG_IDX_W'(i)));
        end
        else if (cfg_wr_en)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        logic signed [COORD_BITS:0] px;
        logic signed [COORD_BITS:0] py;
        logic signed [VW-1:0]       v;
        logic [FIELD_W-1:0]         dz;
        logic [RD_W:0]              rrin;

        px = $signed({1'b0, pixel_x});
        py = $signed({1'b0, pixel_y});
        s1_xsx_next = px * cfg_reg[CFG_X_STEP_X];
        s1_ysx_next = py * cfg_reg[CFG_Y_STEP_X];
        s1_ysy_next = py * cfg_reg[CFG_Y_STEP_Y];
        s1_xsz_next = px * cfg_reg[CFG_X_STEP_Z];
        s1_ysz_next = py * cfg_reg[CFG_Y_STEP_Z];

        s2_v_next[0] = VW'(cfg_reg[CFG_CORNER_X]) + VW'(s1_xsx_reg) + VW'(s1_ysx_reg);
        s2_v_next[1] = VW'(cfg_reg[CFG_CORNER_Y]) + VW'(s1_ysy_reg);
        s2_v_next[2] = VW'(cfg_reg[CFG_CORNER_Z]) + VW'(s1_xsz_reg) + VW'(s1_ysz_reg);

        for (int i = 0; i < 3; i++)
        begin
            s3_neg_next[i] = s2_v_reg[i][VW-1];
            v = s2_v_reg[i][VW-1] ? -s2_v_reg[i] : s2_v_reg[i];
            s3_mag_next[i] = MAG_W'($unsigned(v));
        end

        // signed dir fields and reciprocal numerators
        rc_valid_next[0] = n1_valid;
        for (int i = 0; i < 3; i++)
        begin
            dz = {1'b0, n1_mag[i]};
            rc_side_next[0].zero[i] = (n1_mag[i] == '0);
            rc_side_next[0].rneg[i] = n1_neg[i] && (n1_mag[i] != '0);
            rc_side_next[0].dir[i]  = rc_side_next[0].rneg[i] ? (~dz + 1'b1) : dz;
            rc_d_next[0][i]   = n1_mag[i];
            rc_rem_next[0][i] = '0;
            rc_q_next[0][i]   = '0;
            rc_num_next[0][i] = (RQ_W'(1) << (RQ_W - 1)) + RQ_W'(n1_mag[i] >> 1);
        end
        rc_d_next[0] = n1_mag;

        for (int k = 1; k <= RQ_W; k++)
        begin
            rc_valid_next[k] = rc_valid_reg[k-1];
            rc_side_next[k]  = rc_side_reg[k-1];
            rc_d_next[k]     = rc_d_reg[k-1];
            for (int i = 0; i < 3; i++)
            begin
                rrin = {rc_rem_reg[k-1][i], rc_num_reg[k-1][i][RQ_W-1]};
                rc_num_next[k][i] = rc_num_reg[k-1][i] << 1;
                if (rrin >= {1'b0, rc_d_reg[k-1][i]})
                begin
                    rc_rem_next[k][i] = RD_W'(rrin - {1'b0, rc_d_reg[k-1][i]});
                    rc_q_next[k][i]   = {rc_q_reg[k-1][i][RQ_W-2:0], 1'b1};
                end
                else
                begin
                    rc_rem_next[k][i] = RD_W'(rrin);
                    rc_q_next[k][i]   = {rc_q_reg[k-1][i][RQ_W-2:0], 1'b0};
                end
            end
        end

        // saturate reciprocals of zero components
        for (int i = 0; i < 3; i++)
            rm_mag_next[i] = rc_side_reg[RQ_W].zero[i] ? RECIP_SAT
                                                       : MAG_W'(rc_q_reg[RQ_W][i]);
        rm_side_next.dir  = rc_side_reg[RQ_W].dir;
        rm_side_next.rneg = rc_side_reg[RQ_W].rneg;
        rm_side_next.flag = |rc_side_reg[RQ_W].zero;

        dir_next = n2_side.dir;
        for (int i = 0; i < 3; i++)
        begin
            dz = {1'b0, n2_mag[i]};
            inv_next[i] = (n2_side.rneg[i] && (n2_mag[i] != '0)) ? (~dz + 1'b1) : dz;
        end
    end

    pcrg_norm3 #(
        .SIDE_W (3)
    ) u_norm_dir (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .in_mag    (s3_mag_reg),
        .in_side   (s3_neg_reg),
        .out_valid (n1_valid),
        .out_mag   (n1_mag),
        .out_side  (n1_neg)
    );

    pcrg_norm3 #(
        .SIDE_W ($bits(out_side_t))
    ) u_norm_inv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rm_valid_reg),
        .in_mag    (rm_mag_reg),
        .in_side   (rm_side_reg),
        .out_valid (n2_valid),
        .out_mag   (n2_mag),
        .out_side  (n2_side_bits)
    );

    assign n2_side = out_side_t'(n2_side_bits);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            for (int k = 0; k <= RQ_W; k++)
                rc_valid_reg[k] <= 1'b0;
            rm_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            rc_valid_reg <= rc_valid_next;
            rm_valid_reg <= rc_valid_reg[RQ_W];
            done_reg     <= n2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_xsx_reg  <= s1_xsx_next;
        s1_ysx_reg  <= s1_ysx_next;
        s1_ysy_reg  <= s1_ysy_next;
        s1_xsz_reg  <= s1_xsz_next;
        s1_ysz_reg  <= s1_ysz_next;
        s2_v_reg    <= s2_v_next;
        s3_mag_reg  <= s3_mag_next;
        s3_neg_reg  <= s3_neg_next;
        rc_rem_reg  <= rc_rem_next;
        rc_num_reg  <= rc_num_next;
        rc_q_reg    <= rc_q_next;
        rc_d_reg    <= rc_d_next;
        rc_side_reg <= rc_side_next;
        rm_mag_reg  <= rm_mag_next;
        rm_side_reg <= rm_side_next;
        dir_reg     <= dir_next;
        inv_reg     <= inv_next;
        zero_reg    <= n2_side.flag;
    end

    assign busy           = 1'b0;
    assign done           = done_reg;
    assign dir_x          = dir_reg[0];
    assign dir_y          = dir_reg[1];
    assign dir_z          = dir_reg[2];
    assign inv_x          = inv_reg[0];
    assign inv_y          = inv_reg[1];
    assign inv_z          = inv_reg[2];
    assign zero_component = zero_reg;

endmodule

`default_nettype wire

/* rtl/pcrg_port_checker.sv */
// Port-level checks of the pinhole camera ray generator, bound to the top level.
// Depends on pcrg_pkg and pinhole_camera_ray_generator_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "pinhole_camera_ray_generator_top_assert.svh"

module pcrg_port_checker #(
    parameter int COORD_BITS = 12
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                cfg_wr_en,
    input logic [pcrg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input logic [pcrg_pkg::CFG_W-1:0]          cfg_data,
    input logic                                start,
    input logic                                busy,
    input logic [COORD_BITS-1:0]               pixel_x,
    input logic [COORD_BITS-1:0]               pixel_y,
    input logic                                done,
    input logic signed [pcrg_pkg::FIELD_W-1:0] dir_x,
    input logic signed [pcrg_pkg::FIELD_W-1:0] dir_y,
    input logic signed [pcrg_pkg::FIELD_W-1:0] dir_z,
    input logic signed [pcrg_pkg::FIELD_W-1:0] inv_x,
    input logic signed [pcrg_pkg::FIELD_W-1:0] inv_y,
    input logic signed [pcrg_pkg::FIELD_W-1:0] inv_z,
    input logic                                zero_component
);
    import pcrg_pkg::*;

    // every result traces back to an earlier accepted request
    `PCRG_ASSERT_IMP(a_result_latency, clk, rst_n, done, $past(start && !busy, PIPE_LAT), "result without matching request")
    `PCRG_ASSERT_IMP(a_flag_on_zero, clk, rst_n, done && (dir_x == '0 || dir_y == '0 || dir_z == '0), zero_component, "zero direction component without flag")
    `PCRG_ASSERT_IMP(a_flag_cause, clk, rst_n, done && zero_component, (dir_x == '0 || dir_y == '0 || dir_z == '0), "flag without zero direction component")
    // saturated reciprocals are positive
    `PCRG_ASSERT_NEVER(a_sat_sign, clk, rst_n, done && ((dir_x == '0 && inv_x[FIELD_W-1]) || (dir_y == '0 && inv_y[FIELD_W-1]) || (dir_z == '0 && inv_z[FIELD_W-1])), "negative saturated reciprocal")

endmodule

bind pinhole_camera_ray_generator_top pcrg_port_checker #(
    .COORD_BITS (COORD_BITS)
) u_port_checker (.*);

`default_nettype wire

/* sim/pinhole_camera_ray_generator_top_tb.sv */
// Self-checking testbench for the pinhole camera ray generator.
// Depends on pcrg_pkg and the block's RTL; a scoreboard class predicts each ray.
`timescale 1ns / 1ps
`default_nettype none

module pinhole_camera_ray_generator_top_tb;
    import pcrg_pkg::*;

    localparam int COORD_BITS = 12;
    localparam int LATENCY    = PIPE_LAT + 10;

    typedef struct {
        logic [31:0] dir_x, dir_y, dir_z, inv_x, inv_y, inv_z;
        logic        zero_component;
    } ray_t;

    class ray_scoreboard;
        logic signed [31:0] cam_regs [NUM_CFG];
        ray_t               pending_rays [$];
        int                 errors;
        int                 checked;

        function new();
            errors  = 0;
            checked = 0;
            for (int i = 0; i < NUM_CFG; i++)
                cam_regs[i] = (i == CFG_CORNER_Z) ? 32'shFF00_0000 : 32'sd0;
        endfunction

        function void write_reg(int idx, logic [31:0] value);
            cam_regs[idx] = value;
        endfunction

        function automatic logic [63:0] int_sqrt(logic [63:0] val);
            logic [63:0] root;
            logic [63:0] bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > val)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (val >= root + bitv)
                begin
                    val  = val - (root + bitv);
                    root = (root >> 1) + bitv;
                end
                else
                    root = root >> 1;
                bitv = bitv >> 2;
            end
            return root;
        endfunction

        function automatic void unit_scale(input logic [63:0] mi [3], output logic [63:0] mo [3]);
            logic [63:0]  peak;
            logic [63:0]  a [3];
            logic [63:0]  sum;
            logic [63:0]  len;
            logic [127:0] num;
            int           nbits;
            peak = mi[0];
            if (mi[1] > peak) peak = mi[1];
            if (mi[2] > peak) peak = mi[2];
            sum = 0;
            if (peak == 0)
            begin
                for (int i = 0; i < 3; i++) mo[i] = 0;
                return;
            end
            nbits = 0;
            for (int b = 0; b < 64; b++)
                if (peak[b]) nbits = b + 1;
            for (int i = 0; i < 3; i++)
            begin
                a[i] = (nbits > 31) ? (mi[i] >> (nbits - 31)) : (mi[i] << (31 - nbits));
                sum  = sum + a[i] * a[i];
            end
            len = int_sqrt(sum);
            for (int i = 0; i < 3; i++)
            begin
                num   = ({64'd0, a[i]} << 30) + (len >> 1);
                mo[i] = num / len;
            end
        endfunction

        function void note_request(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
            logic signed [63:0] vec [3];
            logic signed [63:0] sx, sy;
            logic [63:0]        mag [3];
            logic [63:0]        dmag [3];
            logic [63:0]        rmag [3];
            logic [63:0]        imag [3];
            logic               neg [3];
            logic               rneg [3];
            ray_t               r;
            sx = {52'd0, px};
            sy = {52'd0, py};
            vec[0] = 64'(cam_regs[CFG_CORNER_X]) + sx * 64'(cam_regs[CFG_X_STEP_X])
                     + sy * 64'(cam_regs[CFG_Y_STEP_X]);
            vec[1] = 64'(cam_regs[CFG_CORNER_Y]) + sy * 64'(cam_regs[CFG_Y_STEP_Y]);
            vec[2] = 64'(cam_regs[CFG_CORNER_Z]) + sx * 64'(cam_regs[CFG_X_STEP_Z])
                     + sy * 64'(cam_regs[CFG_Y_STEP_Z]);
            for (int i = 0; i < 3; i++)
            begin
                neg[i] = vec[i] < 0;
                mag[i] = neg[i] ? -vec[i] : vec[i];
            end
            unit_scale(mag, dmag);
            r.zero_component = 0;
            for (int i = 0; i < 3; i++)
            begin
                if (dmag[i] == 0)
                begin
                    rmag[i] = RECIP_SAT;
                    rneg[i] = 0;
                    r.zero_component = 1;
                end
                else
                begin
                    rmag[i] = ((64'd1 << 60) + (dmag[i] >> 1)) / dmag[i];
                    rneg[i] = neg[i];
                end
            end
            unit_scale(rmag, imag);
            r.dir_x = (neg[0] && dmag[0] != 0) ? -dmag[0][31:0] : dmag[0][31:0];
            r.dir_y = (neg[1] && dmag[1] != 0) ? -dmag[1][31:0] : dmag[1][31:0];
            r.dir_z = (neg[2] && dmag[2] != 0) ? -dmag[2][31:0] : dmag[2][31:0];
            r.inv_x = (rneg[0] && imag[0] != 0) ? -imag[0][31:0] : imag[0][31:0];
            r.inv_y = (rneg[1] && imag[1] != 0) ? -imag[1][31:0] : imag[1][31:0];
            r.inv_z = (rneg[2] && imag[2] != 0) ? -imag[2][31:0] : imag[2][31:0];
            pending_rays.push_back(r);
        endfunction

        function void check_ray(ray_t got);
            ray_t exp_ray;
            if (pending_rays.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            exp_ray = pending_rays.pop_front();
            checked++;
            if (got.dir_x !== exp_ray.dir_x)
            begin $error("dir_x exp %h got %h", exp_ray.dir_x, got.dir_x); errors++; end
            if (got.dir_y !== exp_ray.dir_y)
            begin $error("dir_y exp %h got %h", exp_ray.dir_y, got.dir_y); errors++; end
            if (got.dir_z !== exp_ray.dir_z)
            begin $error("dir_z exp %h got %h", exp_ray.dir_z, got.dir_z); errors++; end
            if (got.inv_x !== exp_ray.inv_x)
            begin $error("inv_x exp %h got %h", exp_ray.inv_x, got.inv_x); errors++; end
            if (got.inv_y !== exp_ray.inv_y)
            begin $error("inv_y exp %h got %h", exp_ray.inv_y, got.inv_y); errors++; end
            if (got.inv_z !== exp_ray.inv_z)
            begin $error("inv_z exp %h got %h", exp_ray.inv_z, got.inv_z); errors++; end
            if (got.zero_component !== exp_ray.zero_component)
            begin
                $error("zero_component exp %b got %b", exp_ray.zero_component,
                       got.zero_component);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    logic                   start;
    logic                   busy;
    logic [COORD_BITS-1:0]  pixel_x;
    logic [COORD_BITS-1:0]  pixel_y;
    logic                   done;
    logic signed [31:0]     dir_x, dir_y, dir_z, inv_x, inv_y, inv_z;
    logic                   zero_component;

    ray_scoreboard sb;
    int            requests_sent;

    pinhole_camera_ray_generator_top #(.COORD_BITS(COORD_BITS)) DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .start(start), .busy(busy), .pixel_x(pixel_x), .pixel_y(pixel_y),
        .done(done), .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .inv_x(inv_x), .inv_y(inv_y), .inv_z(inv_z), .zero_component(zero_component)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        ray_t got;
        if (rst_n && done)
        begin
            got.dir_x = dir_x; got.dir_y = dir_y; got.dir_z = dir_z;
            got.inv_x = inv_x; got.inv_y = inv_y; got.inv_z = inv_z;
            got.zero_component = zero_component;
            sb.check_ray(got);
        end
    end

    // Block is idle here; every write goes straight in.
    task automatic write_reg(input cfg_idx_e idx, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.write_reg(idx, value);
    endtask

    // Hold start high across back-to-back requests; drop it only for a gap.
    task automatic send_pixel(input logic [COORD_BITS-1:0] px,
                              input logic [COORD_BITS-1:0] py, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        pixel_x <= px;
        pixel_y <= py;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_request(px, py);
        requests_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending_rays.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic load_camera(input logic [31:0] vals [8]);
        drain();
        for (int i = 0; i < NUM_CFG; i++)
            write_reg(cfg_idx_e'(i), vals[i]);
        cfg_wr_en <= 1'b0;
    endtask

    // Small signed step, mostly a fraction of a pixel in Q8.24.
    function automatic logic [31:0] rand_step();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return $urandom;
            default: return 32'(signed'($urandom_range(0, 1 << 17)) - (1 << 16));
        endcase
    endfunction

    task automatic random_burst(input int count, input bit dense);
        for (int n = 0; n < count; n++)
            send_pixel(COORD_BITS'($urandom), COORD_BITS'($urandom),
                       (dense || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15));
    endtask

    initial
    begin
        #(30_000_000);
        $display("pinhole_camera_ray_generator_top_tb: FAIL");
        $finish;
    end

    initial
    begin
        logic [31:0] cam [8];
        sb = new();
        requests_sent = 0;
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        start     = 1'b0;
        pixel_x   = '0;
        pixel_y   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset camera: every pixel looks down -z, x and y components are zero.
        send_pixel(0, 0, 0);
        send_pixel(12'hFFF, 12'hFFF, 0);

        // Zero view vector, then largest magnitudes and extreme pixels.
        cam = '{default: 32'd0};
        load_camera(cam);
        send_pixel(12'h123, 12'hABC, 0);
        cam = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        load_camera(cam);
        send_pixel(0, 0, 0);
        send_pixel(12'hFFF, 0, 1);
        send_pixel(0, 12'hFFF, 0);
        send_pixel(12'hFFF, 12'hFFF, 2);
        send_pixel(12'hAAA, 12'h555, 0);
        send_pixel(12'h555, 12'hAAA, 0);
        drain();

        // Typical camera with the view crossing zero mid-frame.
        cam = '{32'hFF00_0000, 32'hFF00_0000, 32'hFF00_0000, 32'h0000_2000,
                32'h0000_0000, 32'h0000_0000, 32'h0000_2000, 32'h0000_0000};
        load_camera(cam);
        send_pixel(12'd2048, 12'd2048, 0);
        send_pixel(12'd2048, 12'd0, 0);
        send_pixel(12'd0, 12'd2048, 0);
        send_pixel(12'd1, 12'd1, 3);
        send_pixel(12'd4095, 12'd4095, 0);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            for (int i = 0; i < NUM_CFG; i++)
                cam[i] = (i < 3) ? ($urandom_range(0, 3) == 0 ? $urandom
                                    : 32'(signed'($urandom_range(0, 1 << 25)) - (1 << 24)))
                                 : rand_step();
            if (phase == 7)
                cam = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000};
            load_camera(cam);
            random_burst(120, phase[0]);
            // Hold off until the pipeline has emptied, then continue.
            drain();
            random_burst(115, 1'b0);
            drain();
        end

        repeat (LATENCY) @(posedge clk);
        $display("Covered %0d pixels over reset, zero, extreme and 8 random cameras.",
                 requests_sent);
        $display("Checked %0d rays, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending_rays.size() == 0)
            $display("pinhole_camera_ray_generator_top_tb: PASS");
        else
            $display("pinhole_camera_ray_generator_top_tb: FAIL");
        $finish;
    end
endmodule

`default_nettype wire
